/* rtl/nrwm_pkg.sv */
// Shared types and constants for the nearest rating waiting matcher.
`default_nettype none

package nrwm_pkg;

  localparam int RATING_W   = 12;
  localparam int ROOM_IN_W  = 16;
  localparam int STATUS_W   = 3;
  localparam int CFG_ADDR_W = 2;

  localparam logic [RATING_W-1:0]   GAP_RESET          = 12'd200;
  localparam logic [CFG_ADDR_W-1:0] REG_RATING_GAP_ADR = 2'd0;

  localparam logic CMD_JOIN     = 1'b0;
  localparam logic CMD_WITHDRAW = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_MATCHED   = 3'd0,
    ST_OPENED    = 3'd1,
    ST_FULL      = 3'd2,
    ST_WITHDRAWN = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_INSERT = 2'd2
  } op_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic search;
    logic decide;
    logic apply;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/nrwm_ctrl.sv */
// Sequencer for the matcher: capture, search, decide and apply steps.
`default_nettype none

module nrwm_ctrl
  import nrwm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  output ctrl_cmd_t      cmd,
  input  wire dp_stat_t  stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_DEC,
    S_APPLY
  } state_t;

  state_t state_r;
  logic   ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b1;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && ready_r) begin
            state_r <= S_SRCH;
            ready_r <= 1'b0;
          end
        end
        S_SRCH: state_r <= S_DEC;
        S_DEC:  state_r <= S_APPLY;
        S_APPLY: begin
          // The table is only updated together with loading the output register.
          if (stat.out_free) begin
            state_r <= S_IDLE;
            ready_r <= 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
          ready_r <= 1'b1;
        end
      endcase
    end
  end

  assign in_tready   = ready_r;
  assign cmd.capture = (state_r == S_IDLE) && in_tvalid && ready_r;
  assign cmd.search  = (state_r == S_SRCH);
  assign cmd.decide  = (state_r == S_DEC);
  assign cmd.apply   = (state_r == S_APPLY) && stat.out_free;

endmodule

`default_nettype wire

/* rtl/nrwm_datapath.sv */
// Sorted cell row with per-cell compare, neighbor decision and shift logic.
`default_nettype none

module nrwm_datapath
  import nrwm_pkg::*;
#(
  parameter int TABLE_DEPTH  = 64,
  parameter int ROOM_ID_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ctrl_cmd_t            cmd,
  output dp_stat_t                  stat,
  input  wire logic                 in_cmd,
  input  wire logic [RATING_W-1:0]  in_rating,
  input  wire logic [ROOM_IN_W-1:0] in_room,
  input  wire logic [RATING_W-1:0]  rating_gap,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [STATUS_W-1:0]       out_status,
  output logic [ROOM_IN_W-1:0]      out_room
);

  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (ROOM_ID_BITS > ROOM_IN_W) ? ROOM_ID_BITS : ROOM_IN_W;

  // Table cells and fill state.
  logic [RATING_W-1:0]     cell_rating_r [TABLE_DEPTH];
  logic [ROOM_ID_BITS-1:0] cell_room_r   [TABLE_DEPTH];
  logic [CW-1:0]           count_r;
  logic [ROOM_ID_BITS-1:0] next_room_r;

  // Captured item.
  logic                 key_cmd_r;
  logic [RATING_W-1:0]  key_rating_r;
  logic [ROOM_IN_W-1:0] key_room_r;

  // Per-cell search flags.
  logic [TABLE_DEPTH-1:0] vld_r, lt_r, le_r, eq_r;
  logic [RATING_W-1:0]    diff_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] lt_nxt, le_nxt, eq_nxt, vld_nxt;
  logic [RATING_W-1:0]    diff_nxt [TABLE_DEPTH];

  // Decision.
  logic [TABLE_DEPTH-1:0]  qual, pick, first_eq, sel, seen, rm_nxt, rm_r;
  logic [ROOM_ID_BITS-1:0] sel_room, res_nxt, res_r;
  op_t                     op_nxt, op_r;
  status_t                 status_nxt, status_r;
  logic                    found, full;

  // Output register.
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [ROOM_IN_W-1:0] out_room_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_cmd_r    <= in_cmd;
      key_rating_r <= in_rating;
      key_room_r   <= in_room;
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cmp
    assign vld_nxt[i]  = count_r > CW'(i);
    assign lt_nxt[i]   = vld_nxt[i] && (cell_rating_r[i] < key_rating_r);
    assign le_nxt[i]   = vld_nxt[i] && (cell_rating_r[i] <= key_rating_r);
    assign eq_nxt[i]   = vld_nxt[i] && (cell_rating_r[i] == key_rating_r) &&
                         (CMPW'(cell_room_r[i]) == CMPW'(key_room_r));
    assign diff_nxt[i] = (cell_rating_r[i] < key_rating_r) ?
                         key_rating_r - cell_rating_r[i] :
                         cell_rating_r[i] - key_rating_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      vld_r  <= vld_nxt;
      lt_r   <= lt_nxt;
      le_r   <= le_nxt;
      eq_r   <= eq_nxt;
      diff_r <= diff_nxt;
    end
  end

  // The upper candidate is the first valid cell not below the key; the lower
  // candidate is its left neighbor. Each cell settles its pick against that
  // neighbor only, and the upper one wins equal differences.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_pick
    logic up_c, lo_c, up_beaten, lo_beaten;
    assign qual[i] = diff_r[i] <= rating_gap;
    if (i == 0) begin : g_first
      assign up_c        = vld_r[i] && !lt_r[i];
      assign up_beaten   = 1'b0;
      assign first_eq[i] = eq_r[i];
      assign seen[i]     = sel[i];
    end else begin : g_rest
      assign up_c        = vld_r[i] && !lt_r[i] && lt_r[i-1];
      assign up_beaten   = qual[i-1] && (diff_r[i-1] < diff_r[i]);
      assign first_eq[i] = eq_r[i] && !(|eq_r[i-1:0]);
      assign seen[i]     = sel[i] | seen[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign lo_c      = lt_r[i];
      assign lo_beaten = 1'b0;
    end else begin : g_inner
      assign lo_c      = lt_r[i] && !lt_r[i+1];
      assign lo_beaten = vld_r[i+1] && qual[i+1] && (diff_r[i+1] <= diff_r[i]);
    end
    assign pick[i] = qual[i] && ((up_c && !up_beaten) || (lo_c && !lo_beaten));
    assign sel[i]  = (key_cmd_r == CMD_JOIN) ? pick[i] : first_eq[i];
  end

  // Cells at and after the removed one move one place down.
  assign rm_nxt = seen;
  assign found  = |sel;
  assign full   = count_r == CW'(TABLE_DEPTH);

  always_comb begin
    sel_room = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sel_room = sel_room | (sel[i] ? cell_room_r[i] : '0);
    end
  end

  always_comb begin
    res_nxt    = '0;
    op_nxt     = OP_NONE;
    status_nxt = ST_NOT_FOUND;
    if (key_cmd_r == CMD_JOIN) begin
      priority if (found) begin
        op_nxt     = OP_REMOVE;
        status_nxt = ST_MATCHED;
        res_nxt    = sel_room;
      end else if (full) begin
        status_nxt = ST_FULL;
      end else begin
        op_nxt     = OP_INSERT;
        status_nxt = ST_OPENED;
        res_nxt    = next_room_r;
      end
    end else if (found) begin
      op_nxt     = OP_REMOVE;
      status_nxt = ST_WITHDRAWN;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      rm_r     <= rm_nxt;
      res_r    <= res_nxt;
      op_r     <= op_nxt;
      status_r <= status_nxt;
    end
  end

  // Shift the row: a remove pulls the right neighbor in, an insert pushes
  // every cell above the key one place up and drops the new room into the gap.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.apply) begin
        if (op_r == OP_REMOVE && rm_r[i]) begin
          if (i < TABLE_DEPTH - 1) begin
            cell_rating_r[i] <= cell_rating_r[(i < TABLE_DEPTH - 1) ? i + 1 : i];
            cell_room_r[i]   <= cell_room_r[(i < TABLE_DEPTH - 1) ? i + 1 : i];
          end
        end else if (op_r == OP_INSERT && !le_r[i]) begin
          if (i == 0 || le_r[(i > 0) ? i - 1 : 0]) begin
            cell_rating_r[i] <= key_rating_r;
            cell_room_r[i]   <= next_room_r;
          end else begin
            cell_rating_r[i] <= cell_rating_r[(i > 0) ? i - 1 : 0];
            cell_room_r[i]   <= cell_room_r[(i > 0) ? i - 1 : 0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      next_room_r <= ROOM_ID_BITS'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.apply) begin
        out_valid_r <= 1'b1;
        unique case (op_r)
          OP_REMOVE: count_r <= count_r - CW'(1);
          OP_INSERT: begin
            count_r     <= count_r + CW'(1);
            next_room_r <= next_room_r + ROOM_ID_BITS'(1);
          end
          default: ;
        endcase
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_status_r <= status_r;
      out_room_r   <= ROOM_IN_W'(res_r);
    end
  end

  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_status    = out_status_r;
  assign out_room      = out_room_r;

endmodule

`default_nettype wire

/* rtl/nearest_rating_waiting_matcher_unit.sv */
// Top level of the nearest rating waiting matcher.
//
// Input stream (in_*): one item per join or withdraw. in_tuser is the command
// (0 join, 1 withdraw); in_tdata carries rating and room id. Result stream
// (out_*): exactly one item per input, out_tuser is the status and out_tdata
// the matched or opened room id (zero for the other statuses).
// The table is a row of compare-and-shift cells. An item is captured, all
// cells compare against it together, the neighbor decision is made in the
// next, and the row shifts while the result is loaded. The block takes
// one item at a time; the next item can be accepted in the cycle after the
// result is loaded. The result sits in an output register; the next item is
// accepted while it waits, but that item's table update and result load wait
// until the output register is taken. The rating gap is set through the APB
// port at offset 0. Reset empties the table, sets the next room id to one and
// the gap to 200.
`default_nettype none

module nearest_rating_waiting_matcher_unit
  import nrwm_pkg::*;
#(
  parameter int TABLE_DEPTH  = 64,
  parameter int ROOM_ID_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [31:0]           in_tdata,   // rating[11:0], room_id[27:12], zeros
  input  wire logic                  in_tuser,   // cmd[0]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [15:0]                out_tdata,  // result_room[15:0]
  output logic [2:0]                 out_tuser,  // status[2:0]
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  logic [RATING_W-1:0] gap_r;
  ctrl_cmd_t           cmd;
  dp_stat_t            stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= GAP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == REG_RATING_GAP_ADR) begin
      gap_r <= cfg_pwdata[RATING_W-1:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_RATING_GAP_ADR) ? 32'(gap_r) : '0;

  nrwm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  nrwm_datapath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .ROOM_ID_BITS (ROOM_ID_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_cmd     (in_tuser),
    .in_rating  (in_tdata[RATING_W-1:0]),
    .in_room    (in_tdata[RATING_W+ROOM_IN_W-1:RATING_W]),
    .rating_gap (gap_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_tuser),
    .out_room   (out_tdata)
  );

endmodule

`default_nettype wire

/* rtl/nrwm_checker.sv */
// Port-level checks for the matcher and their binding to the top level.
`default_nettype none

module nrwm_checker
  import nrwm_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [15:0]           out_tdata,
  input wire logic [2:0]            out_tuser
);

  // The block works on one item at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while one is in progress");

  // Only the defined status codes are ever shown.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_MATCHED || out_tuser == ST_OPENED ||
                    out_tuser == ST_FULL || out_tuser == ST_WITHDRAWN ||
                    out_tuser == ST_NOT_FOUND))
    else $error("undefined status code");

  // Statuses without a room carry a zero room id.
  a_zero_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL || out_tuser == ST_WITHDRAWN ||
                   out_tuser == ST_NOT_FOUND) |-> out_tdata == '0)
    else $error("room id present on a status without a room");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind nearest_rating_waiting_matcher_unit nrwm_checker u_nrwm_checker (.*);

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for nearest_rating_waiting_matcher_unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nrwm_pkg::*;

  localparam int DEPTH         = 64;
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SEGMENT_ITEMS = 64;
  localparam int IDLE_PCT      = 35;

  typedef struct packed {
    logic                cmd;
    logic [RATING_W-1:0] rating;
    logic [15:0]         room_id;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] room;
  } outcome_t;

  typedef struct packed {
    logic [RATING_W-1:0] rating;
    logic [15:0]         room;
  } waiting_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata    = '0;
  logic                  in_tuser    = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [15:0]           out_tdata;
  logic [2:0]            out_tuser;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]           cfg_pwdata  = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  nearest_rating_waiting_matcher_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block: sorted waiting table, room id counter and gap.
  waiting_t            waiting_table[$];
  waiting_t            opened_log[$];
  logic [15:0]         next_room_id = 16'd1;
  logic [RATING_W-1:0] gap_setting  = GAP_RESET;

  request_t pending_requests[$];
  outcome_t expected_results[$];
  request_t offered_request;

  int queued_count   = 0;
  int accepted_count = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int cycle_count    = 0;
  int id_wraps       = 0;
  int gap_writes     = 0;
  int status_tally[5];
  int idle_pct       = IDLE_PCT;
  bit hold_request   = 1'b0;
  bit hold_done      = 1'b0;
  int hold_left      = 0;

  task automatic predict_outcome(input request_t req);
    int       lo;
    int       pos;
    int       best;
    int       best_diff;
    int       diff;
    bit       found;
    outcome_t res;
    waiting_t entry;
    res.status = ST_NOT_FOUND;
    res.room   = '0;
    found      = 1'b0;
    best       = 0;
    best_diff  = 0;
    lo         = 0;
    if (req.cmd == CMD_JOIN) begin
      while (lo < waiting_table.size() && waiting_table[lo].rating < req.rating) lo++;
      if (lo < waiting_table.size()) begin
        diff = int'(waiting_table[lo].rating) - int'(req.rating);
        if (diff <= int'(gap_setting)) begin
          found     = 1'b1;
          best      = lo;
          best_diff = diff;
        end
      end
      // The lower neighbor only wins with a strictly smaller distance.
      if (lo > 0) begin
        diff = int'(req.rating) - int'(waiting_table[lo-1].rating);
        if (diff <= int'(gap_setting) && (!found || diff < best_diff)) begin
          found = 1'b1;
          best  = lo - 1;
        end
      end
      if (found) begin
        res.status = ST_MATCHED;
        res.room   = waiting_table[best].room;
        waiting_table.delete(best);
      end else if (waiting_table.size() >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        res.status = ST_OPENED;
        res.room   = next_room_id;
        if (next_room_id == 16'hFFFF) id_wraps++;
        next_room_id = next_room_id + 16'd1;
        pos = 0;
        while (pos < waiting_table.size() && waiting_table[pos].rating <= req.rating) pos++;
        entry.rating = req.rating;
        entry.room   = res.room;
        waiting_table.insert(pos, entry);
        opened_log.push_back(entry);
        if (opened_log.size() > 32) void'(opened_log.pop_front());
      end
    end else begin
      pos = 0;
      while (pos < waiting_table.size() &&
             !(waiting_table[pos].rating == req.rating && waiting_table[pos].room == req.room_id))
        pos++;
      if (pos < waiting_table.size()) begin
        waiting_table.delete(pos);
        res.status = ST_WITHDRAWN;
      end
    end
    status_tally[res.status]++;
    expected_results.push_back(res);
  endtask

  // Sender: offers items from the pending queue, idling at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_outcome(offered_request);
        accepted_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
          offered_request = pending_requests.pop_front();
          in_tdata  <= {4'b0, offered_request.room_id, offered_request.rating};
          in_tuser  <= offered_request.cmd;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off that backs the block up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH: unexpected item status=%0d room=%0d", out_tuser, out_tdata);
      end else begin
        want = expected_results.pop_front();
        if (out_tuser !== want.status || out_tdata !== want.room) begin
          mismatches++;
          if (mismatches <= 10)
            $display("MISMATCH at item %0d: expected status=%0d room=%0d, got status=%0d room=%0d",
                     results_seen, want.status, want.room, out_tuser, out_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic queue_request(input logic cmd, input int rating, input int room_id);
    request_t req;
    while (pending_requests.size() >= 4) @(posedge clk);
    req.cmd     = cmd;
    req.rating  = rating[RATING_W-1:0];
    req.room_id = room_id[15:0];
    pending_requests.push_back(req);
    queued_count++;
  endtask

  task automatic wait_until_drained();
    while (accepted_count != queued_count || expected_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_rating_gap(input logic [RATING_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_RATING_GAP_ADR;
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    gap_setting = value;
    gap_writes++;
  endtask

  // Mostly clustered ratings so that joins find partners, some at the range ends.
  function automatic logic [RATING_W-1:0] pick_rating();
    int choice;
    int value;
    choice = $urandom_range(9);
    if (choice < 5)
      value = 500 * $urandom_range(1, 7) + $urandom_range(0, 120) - 60;
    else if (choice < 7)
      value = $urandom_range(1) ? $urandom_range(0, 20) : $urandom_range(4075, 4095);
    else
      value = $urandom_range(4095);
    return value[RATING_W-1:0];
  endfunction

  initial begin
    int       pairs;
    int       choice;
    int       seg_gap;
    waiting_t target;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed joins and withdraws with the reset gap of 200.
    queue_request(CMD_WITHDRAW, 0, 0);       // empty table
    queue_request(CMD_JOIN, 4095, 0);
    queue_request(CMD_JOIN, 0, 0);
    queue_request(CMD_JOIN, 2000, 0);
    queue_request(CMD_JOIN, 2300, 0);
    queue_request(CMD_JOIN, 2150, 0);        // equal distance, upper wins
    queue_request(CMD_JOIN, 2100, 0);
    queue_request(CMD_JOIN, 1000, 0);
    queue_request(CMD_JOIN, 1300, 0);
    queue_request(CMD_JOIN, 1100, 0);        // lower is strictly closer
    queue_request(CMD_JOIN, 4095, 65535);    // exact rating
    queue_request(CMD_JOIN, 200, 0);         // distance exactly the gap
    queue_request(CMD_JOIN, 1501, 0);        // one past the gap
    queue_request(CMD_WITHDRAW, 1300, 7);    // right rating, wrong room
    queue_request(CMD_WITHDRAW, 1501, 6);    // right room, wrong rating
    queue_request(CMD_WITHDRAW, 1300, 6);
    queue_request(CMD_WITHDRAW, 4095, 65535);
    queue_request(CMD_JOIN, 3000, 65535);
    queue_request(CMD_WITHDRAW, 1501, 7);
    queue_request(CMD_WITHDRAW, 3000, 8);
    wait_until_drained();

    // With a zero gap, distinct ratings fill the table until it reports full.
    write_rating_gap('0);
    for (int k = 0; k <= DEPTH; k++) queue_request(CMD_JOIN, k * 63, 0);
    queue_request(CMD_JOIN, 4095, 0);
    queue_request(CMD_WITHDRAW, 4095, 1);
    for (int k = 0; k < DEPTH; k++) queue_request(CMD_JOIN, k * 63, $urandom);
    queue_request(CMD_JOIN, DEPTH * 63, 0);
    queue_request(CMD_JOIN, DEPTH * 63, 0);
    wait_until_drained();

    // Open-then-match pairs with no idling on either side.
    idle_pct = 0;
    pairs = 40;
    for (int p = 0; p < pairs; p++) begin
      choice = $urandom_range(4095);
      queue_request(CMD_JOIN, choice, $urandom);
      queue_request(CMD_JOIN, choice, $urandom);
    end
    wait_until_drained();
    idle_pct = IDLE_PCT;

    for (int seg = 0; seg < 5; seg++) begin
      case (seg)
        0:       seg_gap = $urandom_range(4095);
        1:       seg_gap = 4095;
        2:       seg_gap = 0;
        3:       seg_gap = 37;
        default: seg_gap = $urandom_range(1, 400);
      endcase
      write_rating_gap(seg_gap[RATING_W-1:0]);
      if (seg == 3) hold_request = 1'b1;
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        choice = $urandom_range(99);
        if (choice < 62) begin
          queue_request(CMD_JOIN, pick_rating(), $urandom);
        end else if (choice < 88 && opened_log.size() > 0) begin
          target = opened_log[$urandom_range(opened_log.size() - 1)];
          queue_request(CMD_WITHDRAW, target.rating, target.room);
        end else begin
          queue_request(CMD_WITHDRAW, pick_rating(), $urandom_range(65535));
        end
      end
      wait_until_drained();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d items under %0d gap settings, room id wrapped %0d time(s).",
             accepted_count, gap_writes + 1, id_wraps);
    $display("Outcomes: %0d matched, %0d opened, %0d full, %0d withdrawn, %0d not found.",
             status_tally[ST_MATCHED], status_tally[ST_OPENED], status_tally[ST_FULL],
             status_tally[ST_WITHDRAWN], status_tally[ST_NOT_FOUND]);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/nrwm_pkg.sv
rtl/nrwm_ctrl.sv
rtl/nrwm_datapath.sv
rtl/nearest_rating_waiting_matcher_unit.sv
rtl/nrwm_checker.sv
verif/tb_top.sv
